### sv/ufd_pkg.sv
package ufd_pkg;

  // Frame marker and command codes
  localparam logic [7:0] START_BYTE  = 8'hCD;
  localparam logic [7:0] CMD_WR_DATA = 8'hAB;
  localparam logic [7:0] CMD_END     = 8'hAE;

  // Reserved bytes between payload and CRC
  localparam int unsigned RESERVED_BYTES_DEF = 4;

  // Result status codes
  typedef enum logic [1:0] {
    ST_PAYLOAD   = 2'd0,
    ST_DONE      = 2'd1,
    ST_BAD_START = 2'd2,
    ST_BAD_CMD   = 2'd3
  } status_t;

  // One result item
  typedef struct packed {
    status_t     status;
    logic        command_kind;
    logic [7:0]  payload_byte;
    logic [15:0] payload_index;
    logic        last_payload;
    logic [15:0] frame_length;
    logic [15:0] crc_value;
  } result_t;

  // Handshake between the stages: input stage offers a byte, output stage
  // reports whether it can take a result this cycle
  typedef struct packed {
    logic       valid;
    logic [7:0] data;
  } byte_req_t;

endpackage

### sv/ufd_in_stage.sv
module ufd_in_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        in_data_byte,
  input  logic              out_free,
  output ufd_pkg::byte_req_t req,
  output logic              adv
);

  logic       in_v_r;
  logic [7:0] data_r;

  // Byte moves on whenever the result register has room
  assign adv      = in_v_r && out_free;
  assign in_stall = in_v_r && !out_free;

  assign req.valid = in_v_r;
  assign req.data  = data_r;

  // Input register: reload when the held byte leaves or none is held
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (!in_stall) begin
      in_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      data_r <= in_data_byte;
    end
  end

endmodule

### sv/ufd_parser.sv
module ufd_parser #(
  parameter int unsigned RESERVED_BYTES = ufd_pkg::RESERVED_BYTES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               adv,
  input  ufd_pkg::byte_req_t req,
  output logic               res_valid,
  output ufd_pkg::result_t   res
);

  typedef enum logic [2:0] {
    PH_HUNT     = 3'd0,
    PH_CMD      = 3'd1,
    PH_LEN_LO   = 3'd2,
    PH_LEN_HI   = 3'd3,
    PH_PAYLOAD  = 3'd4,
    PH_RESERVED = 3'd5,
    PH_CRC_LO   = 3'd6,
    PH_CRC_HI   = 3'd7
  } phase_t;

  localparam logic [16:0] RSV_COUNT = 17'(RESERVED_BYTES);
  localparam phase_t      PH_AFTER  = (RESERVED_BYTES == 0) ? PH_CRC_LO : PH_RESERVED;

  phase_t      phase_r,  phase_nxt;
  logic        cmd_r,    cmd_nxt;
  logic [15:0] len_r,    len_nxt;
  logic [15:0] cnt_r,    cnt_nxt;
  logic [7:0]  crc_lo_r, crc_lo_nxt;

  logic [7:0]  b;
  logic [15:0] len_full;
  logic [16:0] cnt_inc;

  assign b        = req.data;
  assign len_full = {b, len_r[7:0]};
  assign cnt_inc  = {1'b0, cnt_r} + 17'd1;

  // Next state and result for the byte in the input register
  always_comb begin
    phase_nxt  = phase_r;
    cmd_nxt    = cmd_r;
    len_nxt    = len_r;
    cnt_nxt    = cnt_r;
    crc_lo_nxt = crc_lo_r;
    res_valid  = 1'b0;
    res        = '0;

    case (phase_r)
      PH_HUNT: begin
        if (b == ufd_pkg::START_BYTE) begin
          phase_nxt = PH_CMD;
        end else begin
          res_valid  = 1'b1;
          res.status = ufd_pkg::ST_BAD_START;
        end
      end
      PH_CMD: begin
        if (b == ufd_pkg::CMD_WR_DATA || b == ufd_pkg::CMD_END) begin
          cmd_nxt   = (b == ufd_pkg::CMD_END);
          phase_nxt = PH_LEN_LO;
        end else begin
          // bad command byte is retried as a start byte
          phase_nxt  = (b == ufd_pkg::START_BYTE) ? PH_CMD : PH_HUNT;
          res_valid  = 1'b1;
          res.status = ufd_pkg::ST_BAD_CMD;
        end
      end
      PH_LEN_LO: begin
        len_nxt   = {8'd0, b};
        phase_nxt = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        len_nxt   = len_full;
        cnt_nxt   = '0;
        phase_nxt = (len_full == 16'd0) ? PH_AFTER : PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        res_valid         = 1'b1;
        res.status        = ufd_pkg::ST_PAYLOAD;
        res.command_kind  = cmd_r;
        res.payload_byte  = b;
        res.payload_index = cnt_r;
        res.last_payload  = (cnt_inc >= {1'b0, len_r});
        if (res.last_payload) begin
          cnt_nxt   = '0;
          phase_nxt = PH_AFTER;
        end else begin
          cnt_nxt = cnt_inc[15:0];
        end
      end
      PH_RESERVED: begin
        if (cnt_inc >= RSV_COUNT) begin
          cnt_nxt   = '0;
          phase_nxt = PH_CRC_LO;
        end else begin
          cnt_nxt = cnt_inc[15:0];
        end
      end
      PH_CRC_LO: begin
        crc_lo_nxt = b;
        phase_nxt  = PH_CRC_HI;
      end
      PH_CRC_HI: begin
        res_valid        = 1'b1;
        res.status       = ufd_pkg::ST_DONE;
        res.command_kind = cmd_r;
        res.frame_length = len_r;
        res.crc_value    = {b, crc_lo_r};
        cnt_nxt          = '0;
        phase_nxt        = PH_HUNT;
      end
      default: begin
        phase_nxt = PH_HUNT;
      end
    endcase
  end

  // Parser state, updated once per byte transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HUNT;
      cmd_r    <= 1'b0;
      len_r    <= '0;
      cnt_r    <= '0;
      crc_lo_r <= '0;
    end else if (adv) begin
      phase_r  <= phase_nxt;
      cmd_r    <= cmd_nxt;
      len_r    <= len_nxt;
      cnt_r    <= cnt_nxt;
      crc_lo_r <= crc_lo_nxt;
    end
  end

endmodule

### sv/ufd_out_stage.sv
module ufd_out_stage (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             adv,
  input  logic             res_valid,
  input  ufd_pkg::result_t res,
  output logic             out_free,
  output logic             out_valid,
  input  logic             out_stall,
  output ufd_pkg::result_t out_res
);

  logic             out_v_r;
  ufd_pkg::result_t res_r;

  // Room when empty or when the held result leaves this cycle
  assign out_free  = !out_v_r || !out_stall;
  assign out_valid = out_v_r;
  assign out_res   = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= res_valid;
    end else if (!out_stall) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && res_valid) begin
      res_r <= res;
    end
  end

endmodule

### sv/update_frame_deframer_core.sv
// Channel  | Ports                                     | Direction
// ---------+-------------------------------------------+----------
// input    | in_valid, in_stall, in_data_byte          | in
// result   | out_valid, out_stall, out_status .. crc   | out
//
// One byte per cycle sustained while the result side does not stall; each
// byte is held in the input register, and its result, if any, is then
// registered in the result register, where result valid rises.
// Synchronous active-low reset returns the parser to start-byte hunting.
// A stalled result holds the result register; the input register still
// takes a byte and stalls only once it is also full.
module update_frame_deframer_core #(
  parameter int unsigned RESERVED_BYTES = ufd_pkg::RESERVED_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic        out_command_kind,
  output logic [7:0]  out_payload_byte,
  output logic [15:0] out_payload_index,
  output logic        out_last_payload,
  output logic [15:0] out_frame_length,
  output logic [15:0] out_crc_value
);

  ufd_pkg::byte_req_t req;
  ufd_pkg::result_t   res;
  ufd_pkg::result_t   out_res;
  logic               adv;
  logic               out_free;
  logic               res_valid;

  ufd_in_stage u_in (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data_byte (in_data_byte),
    .out_free     (out_free),
    .req          (req),
    .adv          (adv)
  );

  ufd_parser #(
    .RESERVED_BYTES (RESERVED_BYTES)
  ) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .req       (req),
    .res_valid (res_valid),
    .res       (res)
  );

  ufd_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .res_valid (res_valid),
    .res       (res),
    .out_free  (out_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign out_status        = out_res.status;
  assign out_command_kind  = out_res.command_kind;
  assign out_payload_byte  = out_res.payload_byte;
  assign out_payload_index = out_res.payload_index;
  assign out_last_payload  = out_res.last_payload;
  assign out_frame_length  = out_res.frame_length;
  assign out_crc_value     = out_res.crc_value;

endmodule

### sv/ufd_checker.sv
module ufd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic [7:0]  in_data_byte,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  out_status,
  input logic        out_command_kind,
  input logic [7:0]  out_payload_byte,
  input logic [15:0] out_payload_index,
  input logic        out_last_payload,
  input logic [15:0] out_frame_length,
  input logic [15:0] out_crc_value
);

  // Input side backs up only behind a stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled while result side can take a transfer");

  // A stalled input byte stays put until its transfer
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_stall) |=> (in_valid && $stable(in_data_byte)))
    else $error("input byte changed while stalled");

  // Payload-only fields are clear on every other status
  a_payload_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ufd_pkg::ST_PAYLOAD) |->
      (out_payload_byte == 8'd0 && out_payload_index == 16'd0 &&
       out_last_payload == 1'b0))
    else $error("payload fields set on a non-payload result");

  // Error results carry no frame information
  a_error_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == ufd_pkg::ST_BAD_START ||
                   out_status == ufd_pkg::ST_BAD_CMD)) |->
      (out_command_kind == 1'b0 && out_frame_length == 16'd0 &&
       out_crc_value == 16'd0))
    else $error("frame fields set on an error result");

  // A stalled result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=>
      (out_valid && $stable(out_status) && $stable(out_payload_index) &&
       $stable(out_crc_value)))
    else $error("result changed while stalled");

endmodule

bind update_frame_deframer_core ufd_checker u_ufd_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_stall          (in_stall),
  .in_data_byte      (in_data_byte),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_status        (out_status),
  .out_command_kind  (out_command_kind),
  .out_payload_byte  (out_payload_byte),
  .out_payload_index (out_payload_index),
  .out_last_payload  (out_last_payload),
  .out_frame_length  (out_frame_length),
  .out_crc_value     (out_crc_value)
);

### sim/update_frame_deframer_core_tb.sv
`timescale 1ns / 1ps

module update_frame_deframer_core_tb;

  localparam int unsigned RSVD_COUNT   = ufd_pkg::RESERVED_BYTES_DEF;
  localparam int unsigned RANDOM_BYTES = 1520;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned DRAIN_CYCLES = 8;

  // Parser position, tracked by the predictor
  typedef enum logic [2:0] {
    SEEK_START, GET_CMD, GET_LEN_LO, GET_LEN_HI,
    GET_PAYLOAD, SKIP_RSVD, GET_CRC_LO, GET_CRC_HI
  } parse_phase_t;

  // Receiver back-pressure styles
  typedef enum logic [1:0] {
    STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC
  } stall_mode_t;

  // One directed byte; pinned rows carry a hand-written expectation
  typedef struct {
    logic [7:0]       data;
    bit               pinned;
    bit               has_result;
    ufd_pkg::result_t res;
  } byte_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_data_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_status;
  logic        out_command_kind;
  logic [7:0]  out_payload_byte;
  logic [15:0] out_payload_index;
  logic        out_last_payload;
  logic [15:0] out_frame_length;
  logic [15:0] out_crc_value;

  update_frame_deframer_core dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_data_byte      (in_data_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_command_kind  (out_command_kind),
    .out_payload_byte  (out_payload_byte),
    .out_payload_index (out_payload_index),
    .out_last_payload  (out_last_payload),
    .out_frame_length  (out_frame_length),
    .out_crc_value     (out_crc_value)
  );

  // Predictor state
  parse_phase_t parse_phase  = SEEK_START;
  logic         cmd_is_end   = 1'b0;
  logic [15:0]  frame_len    = '0;
  logic [15:0]  payload_pos  = '0;
  logic [7:0]   crc_lo       = '0;

  ufd_pkg::result_t pending_results[$];
  byte_row_t        directed_rows[$];
  logic [7:0]       stim_bytes[$];

  int unsigned cycle_count = 0;
  int unsigned mismatches  = 0;
  int unsigned bytes_sent  = 0;
  int unsigned burst_left  = 0;
  int unsigned n_payload   = 0;
  int unsigned n_done      = 0;
  int unsigned n_bad_start = 0;
  int unsigned n_bad_cmd   = 0;

  stall_mode_t stall_mode = STALL_NONE;
  int unsigned stall_left = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  // Cycle counter and run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("tb: failure");
      $finish;
    end
  end

  function automatic ufd_pkg::result_t err_result(ufd_pkg::status_t s);
    ufd_pkg::result_t r;
    r = '0;
    r.status = s;
    return r;
  endfunction

  function automatic ufd_pkg::result_t done_result(logic cmd, logic [15:0] len,
                                                   logic [15:0] crc);
    ufd_pkg::result_t r;
    r = '0;
    r.status = ufd_pkg::ST_DONE;
    r.command_kind = cmd;
    r.frame_length = len;
    r.crc_value = crc;
    return r;
  endfunction

  // Payload finished (or empty): skip reserved bytes, or go straight to CRC
  function automatic void end_of_payload();
    payload_pos = '0;
    parse_phase = (RSVD_COUNT == 0) ? GET_CRC_LO : SKIP_RSVD;
  endfunction

  // Advance the parser by one byte; returns 1 when the byte yields a result
  function automatic bit deframe_byte(input logic [7:0] b, output ufd_pkg::result_t r);
    bit produced;
    bit last;
    r = '0;
    produced = 1'b0;
    case (parse_phase)
      SEEK_START: begin
        if (b == ufd_pkg::START_BYTE) begin
          parse_phase = GET_CMD;
        end else begin
          r.status = ufd_pkg::ST_BAD_START;
          produced = 1'b1;
        end
      end
      GET_CMD: begin
        if (b == ufd_pkg::CMD_WR_DATA || b == ufd_pkg::CMD_END) begin
          cmd_is_end = (b == ufd_pkg::CMD_END);
          parse_phase = GET_LEN_LO;
        end else begin
          // the rejected byte may itself be a start marker
          parse_phase = (b == ufd_pkg::START_BYTE) ? GET_CMD : SEEK_START;
          r.status = ufd_pkg::ST_BAD_CMD;
          produced = 1'b1;
        end
      end
      GET_LEN_LO: begin
        frame_len = {8'h00, b};
        parse_phase = GET_LEN_HI;
      end
      GET_LEN_HI: begin
        frame_len[15:8] = b;
        payload_pos = '0;
        if (frame_len == 16'd0) end_of_payload();
        else parse_phase = GET_PAYLOAD;
      end
      GET_PAYLOAD: begin
        last = ({1'b0, payload_pos} + 17'd1) >= {1'b0, frame_len};
        r.status = ufd_pkg::ST_PAYLOAD;
        r.command_kind = cmd_is_end;
        r.payload_byte = b;
        r.payload_index = payload_pos;
        r.last_payload = last;
        produced = 1'b1;
        if (last) end_of_payload();
        else payload_pos = payload_pos + 16'd1;
      end
      SKIP_RSVD: begin
        payload_pos = payload_pos + 16'd1;
        if (payload_pos >= 16'(RSVD_COUNT)) begin
          payload_pos = '0;
          parse_phase = GET_CRC_LO;
        end
      end
      GET_CRC_LO: begin
        crc_lo = b;
        parse_phase = GET_CRC_HI;
      end
      default: begin
        r.status = ufd_pkg::ST_DONE;
        r.command_kind = cmd_is_end;
        r.frame_length = frame_len;
        r.crc_value = {b, crc_lo};
        parse_phase = SEEK_START;
        payload_pos = '0;
        produced = 1'b1;
      end
    endcase
    return produced;
  endfunction

  task automatic add_row(logic [7:0] data, bit pinned, bit has_result,
                         ufd_pkg::result_t res);
    byte_row_t row;
    row.data = data;
    row.pinned = pinned;
    row.has_result = has_result;
    row.res = res;
    directed_rows.push_back(row);
  endtask

  // Offer one byte in bursts with random gaps; log the expectation on transfer
  task automatic send_byte(logic [7:0] b, bit pinned, bit pin_has,
                           ufd_pkg::result_t pin_res);
    int unsigned      gap;
    bit               got;
    ufd_pkg::result_t r;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 24);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left = burst_left - 1;
    in_valid <= 1'b1;
    in_data_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    got = deframe_byte(b, r);
    if (pinned) begin
      got = pin_has;
      r = pin_res;
    end
    if (got) pending_results.push_back(r);
    bytes_sent++;
  endtask

  // Receiver back-pressure: segments of different stall styles
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= stall_mode_t'($urandom_range(0, 3));
      stall_left <= $urandom_range(20, 200);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      STALL_NONE:     out_stall <= 1'b0;
      STALL_LIGHT:    out_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY:    out_stall <= ($urandom_range(0, 3) != 0);
      STALL_PERIODIC: out_stall <= (cycle_count[2:0] < 3'd3);
      default:        out_stall <= 1'b0;
    endcase
  end

  task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Compare each result transfer with the oldest expectation
  always @(posedge clk) begin
    ufd_pkg::result_t want;
    if (rst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, status %0h", $time, out_status);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        check_field("status", 16'(want.status), 16'(out_status));
        check_field("command_kind", 16'(want.command_kind), 16'(out_command_kind));
        check_field("payload_byte", 16'(want.payload_byte), 16'(out_payload_byte));
        check_field("payload_index", want.payload_index, out_payload_index);
        check_field("last_payload", 16'(want.last_payload), 16'(out_last_payload));
        check_field("frame_length", want.frame_length, out_frame_length);
        check_field("crc_value", want.crc_value, out_crc_value);
        case (want.status)
          ufd_pkg::ST_PAYLOAD:   n_payload++;
          ufd_pkg::ST_DONE:      n_done++;
          ufd_pkg::ST_BAD_START: n_bad_start++;
          default:               n_bad_cmd++;
        endcase
      end
    end
  end

  initial begin
    int unsigned pick;
    int unsigned len;
    int unsigned big_frames;
    int unsigned k;
    logic [7:0]  b;

    big_frames = 0;

    // Directed: errors, command rescan, two-byte write frame, empty end frame
    add_row(8'h00, 1'b1, 1'b1, err_result(ufd_pkg::ST_BAD_START));
    add_row(8'hFF, 1'b1, 1'b1, err_result(ufd_pkg::ST_BAD_START));
    add_row(ufd_pkg::START_BYTE, 1'b1, 1'b0, '0);
    add_row(8'h12, 1'b1, 1'b1, err_result(ufd_pkg::ST_BAD_CMD));
    add_row(ufd_pkg::START_BYTE, 1'b1, 1'b0, '0);
    add_row(ufd_pkg::START_BYTE, 1'b1, 1'b1, err_result(ufd_pkg::ST_BAD_CMD));
    add_row(ufd_pkg::CMD_WR_DATA, 1'b1, 1'b0, '0);
    add_row(8'h02, 1'b1, 1'b0, '0);
    add_row(8'h00, 1'b1, 1'b0, '0);
    add_row(8'h00, 1'b0, 1'b0, '0);
    add_row(8'hFF, 1'b0, 1'b0, '0);
    add_row(8'hFF, 1'b1, 1'b0, '0);
    add_row(8'h00, 1'b1, 1'b0, '0);
    add_row(ufd_pkg::START_BYTE, 1'b1, 1'b0, '0);
    add_row(ufd_pkg::CMD_WR_DATA, 1'b1, 1'b0, '0);
    add_row(8'h34, 1'b1, 1'b0, '0);
    add_row(8'h12, 1'b1, 1'b1, done_result(1'b0, 16'd2, 16'h1234));
    add_row(ufd_pkg::START_BYTE, 1'b1, 1'b0, '0);
    add_row(ufd_pkg::CMD_END, 1'b1, 1'b0, '0);
    add_row(8'h00, 1'b1, 1'b0, '0);
    add_row(8'h00, 1'b1, 1'b0, '0);
    for (k = 0; k < RSVD_COUNT; k++) add_row(8'h00, 1'b1, 1'b0, '0);
    add_row(8'hFF, 1'b1, 1'b0, '0);
    add_row(8'hFF, 1'b1, 1'b1, done_result(1'b1, 16'd0, 16'hFFFF));

    // Random stream: mostly well-formed frames, some noise and broken headers
    while (stim_bytes.size() < RANDOM_BYTES) begin
      pick = $urandom_range(0, 99);
      if (pick < 75) begin
        len = $urandom_range(0, 99);
        if (len < 2 && big_frames < 3) begin
          len = $urandom_range(256, 300);
          big_frames++;
        end else if (len < 60) begin
          len = $urandom_range(0, 4);
        end else begin
          len = $urandom_range(5, 40);
        end
        stim_bytes.push_back(ufd_pkg::START_BYTE);
        stim_bytes.push_back($urandom_range(0, 1) ? ufd_pkg::CMD_END
                                                  : ufd_pkg::CMD_WR_DATA);
        stim_bytes.push_back(len[7:0]);
        stim_bytes.push_back(len[15:8]);
        for (k = 0; k < len + RSVD_COUNT + 2; k++)
          stim_bytes.push_back(8'($urandom_range(0, 255)));
      end else if (pick < 85) begin
        for (k = $urandom_range(1, 6); k > 0; k--)
          stim_bytes.push_back(8'($urandom_range(0, 255)));
      end else begin
        // start marker followed by a rejected command, possibly another marker
        stim_bytes.push_back(ufd_pkg::START_BYTE);
        do b = 8'($urandom_range(0, 255));
        while (b == ufd_pkg::CMD_WR_DATA || b == ufd_pkg::CMD_END);
        stim_bytes.push_back((pick < 90) ? ufd_pkg::START_BYTE : b);
      end
    end

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i])
      send_byte(directed_rows[i].data, directed_rows[i].pinned,
                directed_rows[i].has_result, directed_rows[i].res);
    foreach (stim_bytes[i]) send_byte(stim_bytes[i], 1'b0, 1'b0, '0);
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run covered %0d input bytes in %0d cycles", bytes_sent, cycle_count);
    $display("results checked: %0d payload, %0d frame done, %0d bad start, %0d bad command",
             n_payload, n_done, n_bad_start, n_bad_cmd);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

### filelist.f
sv/ufd_pkg.sv
sv/ufd_in_stage.sv
sv/ufd_parser.sv
sv/ufd_out_stage.sv
sv/update_frame_deframer_core.sv
sv/ufd_checker.sv
sim/update_frame_deframer_core_tb.sv
